FILE: src/mms_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Matrix multiply with minimum search: shared definitions
// Sizes, request codes and the word layouts used by the block and its core.
// ----------------------------------------------------------------------------
package mms_pkg;

    // Matrix dimension and the widths that follow from it.
    localparam int DIM    = 16;
    localparam int IDX_W  = $clog2(DIM);
    localparam int AW     = $clog2(DIM * DIM);
    localparam int FLD_W  = 4;
    localparam int ELEM_W = 16;
    localparam int PROD_W = 2 * ELEM_W;
    localparam int ACC_W  = PROD_W + $clog2(DIM);
    localparam int OUT_W  = 36;
    localparam int EXT_W  = (ACC_W > OUT_W) ? ACC_W : OUT_W;

    // Request codes.
    localparam logic [1:0] REQ_LOAD_A  = 2'd0;
    localparam logic [1:0] REQ_LOAD_B  = 2'd1;
    localparam logic [1:0] REQ_COMPUTE = 2'd2;
    localparam logic [1:0] REQ_READ    = 2'd3;

    // Status codes.
    localparam logic STATUS_OK         = 1'b0;
    localparam logic STATUS_NO_PRODUCT = 1'b1;

    // Request word.
    typedef struct packed {
        logic [1:0]               req_type;
        logic [FLD_W-1:0]         row;
        logic [FLD_W-1:0]         col;
        logic signed [ELEM_W-1:0] elem_value;
    } t_req;

    // Response word.
    typedef struct packed {
        logic                    status;
        logic signed [OUT_W-1:0] product_value;
        logic signed [OUT_W-1:0] min_value;
        logic [FLD_W-1:0]        min_row;
        logic [FLD_W-1:0]        min_col;
    } t_rsp;

    // Commands from the request control to the arithmetic core.
    typedef struct packed {
        logic                     we_a;
        logic                     we_b;
        logic                     start;
        logic                     rd_en;
        logic [AW-1:0]            addr;
        logic signed [ELEM_W-1:0] wdata;
    } t_core_cmd;

    // Minimum found by the last product.
    typedef struct packed {
        logic signed [OUT_W-1:0] value;
        logic [FLD_W-1:0]        row;
        logic [FLD_W-1:0]        col;
    } t_min;

endpackage
`default_nettype wire

FILE: src/mms_req_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel that carries one request word.
// ----------------------------------------------------------------------------
interface mms_req_if;
    logic          valid;
    logic          ready;
    mms_pkg::t_req data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: src/mms_rsp_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel that carries one response word.
// ----------------------------------------------------------------------------
interface mms_rsp_if;
    logic          valid;
    logic          ready;
    mms_pkg::t_rsp data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: src/mms_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Matrix multiply core
// Holds the A, B and C stores and runs one shared multiply-accumulate unit
// over every (i, j, k), saturating each sum and tracking the smallest one.
// ----------------------------------------------------------------------------
module mms_core (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire mms_pkg::t_core_cmd i_cmd,
    output logic                    o_busy,
    output logic signed [mms_pkg::OUT_W-1:0] o_c_rdata,
    output mms_pkg::t_min           o_min
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_RUN   = 2'd1;
    localparam logic [1:0] S_DRAIN = 2'd2;

    localparam logic [mms_pkg::IDX_W-1:0] IDX_LAST = mms_pkg::IDX_W'(mms_pkg::DIM - 1);
    localparam logic signed [mms_pkg::OUT_W-1:0] SAT_MAX =
        {1'b0, {(mms_pkg::OUT_W-1){1'b1}}};
    localparam logic signed [mms_pkg::OUT_W-1:0] SAT_MIN =
        {1'b1, {(mms_pkg::OUT_W-1){1'b0}}};

    // Stores.
    logic signed [mms_pkg::ELEM_W-1:0] r_a_mem [mms_pkg::DIM*mms_pkg::DIM];
    logic signed [mms_pkg::ELEM_W-1:0] r_b_mem [mms_pkg::DIM*mms_pkg::DIM];
    logic signed [mms_pkg::OUT_W-1:0]  r_c_mem [mms_pkg::DIM*mms_pkg::DIM];

    logic [1:0]               r_state, n_state;
    logic [mms_pkg::IDX_W-1:0] r_i, r_j, r_k;

    // Pipeline registers.
    logic signed [mms_pkg::ELEM_W-1:0] r_a_q, r_b_q;
    logic                              r_s1_vld, r_s1_first, r_s1_last;
    logic [mms_pkg::IDX_W-1:0]         r_s1_i, r_s1_j;
    logic signed [mms_pkg::PROD_W-1:0] r_prod;
    logic                              r_s2_vld, r_s2_first, r_s2_last;
    logic [mms_pkg::IDX_W-1:0]         r_s2_i, r_s2_j;
    logic signed [mms_pkg::ACC_W-1:0]  r_acc;
    logic                              r_s3_done;
    logic [mms_pkg::IDX_W-1:0]         r_s3_i, r_s3_j;

    logic signed [mms_pkg::OUT_W-1:0]  r_c_q;
    logic signed [mms_pkg::OUT_W-1:0]  r_min_val;
    logic [mms_pkg::IDX_W-1:0]         r_min_i, r_min_j;

    logic [mms_pkg::AW-1:0]            w_a_addr, w_b_addr, w_c_addr;
    logic signed [mms_pkg::EXT_W-1:0]  w_ext;
    logic signed [mms_pkg::OUT_W-1:0]  w_sat;
    logic                              w_first_elem;
    logic                              w_pipe_empty;
    logic [mms_pkg::IDX_W+mms_pkg::FLD_W-1:0] w_row_ext, w_col_ext;

    // Operand and result addresses, row-major.
    assign w_a_addr = mms_pkg::AW'(mms_pkg::AW'(r_i) * mms_pkg::AW'(mms_pkg::DIM))
                    + mms_pkg::AW'(r_k);
    assign w_b_addr = mms_pkg::AW'(mms_pkg::AW'(r_k) * mms_pkg::AW'(mms_pkg::DIM))
                    + mms_pkg::AW'(r_j);
    assign w_c_addr = mms_pkg::AW'(mms_pkg::AW'(r_s3_i) * mms_pkg::AW'(mms_pkg::DIM))
                    + mms_pkg::AW'(r_s3_j);

    // Sequencer.
    assign w_pipe_empty = !r_s1_vld && !r_s2_vld && !r_s3_done;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_cmd.start) begin
                    n_state = S_RUN;
                end
            end
            S_RUN: begin
                if (r_i == IDX_LAST && r_j == IDX_LAST && r_k == IDX_LAST) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (w_pipe_empty) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_i     <= '0;
            r_j     <= '0;
            r_k     <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_RUN) begin
                if (r_k == IDX_LAST) begin
                    r_k <= '0;
                    if (r_j == IDX_LAST) begin
                        r_j <= '0;
                        r_i <= (r_i == IDX_LAST) ? '0 : r_i + 1'b1;
                    end else begin
                        r_j <= r_j + 1'b1;
                    end
                end else begin
                    r_k <= r_k + 1'b1;
                end
            end
        end
    end

    // A and B stores: loads write, the sequencer reads one pair a cycle.
    always_ff @(posedge i_clk) begin
        if (i_cmd.we_a) begin
            r_a_mem[i_cmd.addr] <= i_cmd.wdata;
        end
        if (i_cmd.we_b) begin
            r_b_mem[i_cmd.addr] <= i_cmd.wdata;
        end
        r_a_q <= r_a_mem[w_a_addr];
        r_b_q <= r_b_mem[w_b_addr];
    end

    // Pipeline control bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_s2_vld  <= 1'b0;
            r_s3_done <= 1'b0;
        end else begin
            r_s1_vld  <= (r_state == S_RUN);
            r_s2_vld  <= r_s1_vld;
            r_s3_done <= r_s2_vld && r_s2_last;
        end
    end

    // Multiply, then accumulate over k.
    always_ff @(posedge i_clk) begin
        r_s1_first <= (r_k == '0);
        r_s1_last  <= (r_k == IDX_LAST);
        r_s1_i     <= r_i;
        r_s1_j     <= r_j;
        r_prod     <= r_a_q * r_b_q;
        r_s2_first <= r_s1_first;
        r_s2_last  <= r_s1_last;
        r_s2_i     <= r_s1_i;
        r_s2_j     <= r_s1_j;
        r_s3_i     <= r_s2_i;
        r_s3_j     <= r_s2_j;
        if (r_s2_vld) begin
            r_acc <= (r_s2_first ? '0 : r_acc) + mms_pkg::ACC_W'(r_prod);
        end
    end

    // Saturate the finished sum to the result width.
    always_comb begin
        w_ext = mms_pkg::EXT_W'(r_acc);
        if (w_ext > mms_pkg::EXT_W'(SAT_MAX)) begin
            w_sat = SAT_MAX;
        end else if (w_ext < mms_pkg::EXT_W'(SAT_MIN)) begin
            w_sat = SAT_MIN;
        end else begin
            w_sat = mms_pkg::OUT_W'(w_ext);
        end
    end

    assign w_first_elem = (r_s3_i == '0) && (r_s3_j == '0);

    // C store: written by the sequencer, read for read requests.
    always_ff @(posedge i_clk) begin
        if (r_s3_done) begin
            r_c_mem[w_c_addr] <= w_sat;
        end
        if (i_cmd.rd_en) begin
            r_c_q <= r_c_mem[i_cmd.addr];
        end
    end

    // Running minimum, strict less-than in row-major order.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_val <= '0;
            r_min_i   <= '0;
            r_min_j   <= '0;
        end else if (r_s3_done && (w_first_elem || w_sat < r_min_val)) begin
            r_min_val <= w_sat;
            r_min_i   <= r_s3_i;
            r_min_j   <= r_s3_j;
        end
    end

    // The minimum's indices go out as their low field bits.
    assign w_row_ext = {{mms_pkg::FLD_W{1'b0}}, r_min_i};
    assign w_col_ext = {{mms_pkg::FLD_W{1'b0}}, r_min_j};

    assign o_busy      = (r_state != S_IDLE);
    assign o_c_rdata   = r_c_q;
    assign o_min.value = r_min_val;
    assign o_min.row   = w_row_ext[mms_pkg::FLD_W-1:0];
    assign o_min.col   = w_col_ext[mms_pkg::FLD_W-1:0];

endmodule
`default_nettype wire

FILE: src/matrix_multiply_with_min_search_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Matrix multiply with minimum search
// Loads two square Q8.8 matrices, forms their Q20.16 product and its minimum,
// and answers read requests with one product element and the minimum.
// ----------------------------------------------------------------------------
// Each request word gives exactly one response word. Load and compute requests
// are answered with a zero word; a load also invalidates any earlier product.
// A read waits for the C store read, which is registered. A compute request
// holds the request channel while the core is busy: a single multiplier and
// accumulator steps through every (i, j, k) with one A and one B store read
// a cycle. Reads made before any product exists, or after a later load,
// answer with status 1.
// ----------------------------------------------------------------------------
module matrix_multiply_with_min_search_top (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    mms_req_if.sink    i_req,
    mms_rsp_if.source  o_rsp
);

    mms_pkg::t_core_cmd w_cmd;
    logic               w_busy;
    logic signed [mms_pkg::OUT_W-1:0] w_c_rdata;
    mms_pkg::t_min      w_min;

    logic               w_accept;
    logic               w_in_range;
    logic               w_is_load;

    logic               r_out_vld;
    mms_pkg::t_rsp      r_out;
    logic               r_rd_pend;
    logic               r_rd_in_range;
    logic               r_rd_ok;
    logic               r_product_ready;

    // Accept a word only when the core is free, no read is pending and the output slot will be.
    assign i_req.ready = !w_busy && !r_rd_pend && (!r_out_vld || o_rsp.ready);
    assign w_accept    = i_req.valid && i_req.ready;

    assign w_in_range = (8'(i_req.data.row) < 8'(mms_pkg::DIM))
                     && (8'(i_req.data.col) < 8'(mms_pkg::DIM));
    assign w_is_load  = (i_req.data.req_type == mms_pkg::REQ_LOAD_A)
                     || (i_req.data.req_type == mms_pkg::REQ_LOAD_B);

    // Commands to the core.
    always_comb begin
        w_cmd.we_a  = w_accept && w_in_range
                   && (i_req.data.req_type == mms_pkg::REQ_LOAD_A);
        w_cmd.we_b  = w_accept && w_in_range
                   && (i_req.data.req_type == mms_pkg::REQ_LOAD_B);
        w_cmd.start = w_accept && (i_req.data.req_type == mms_pkg::REQ_COMPUTE);
        w_cmd.rd_en = w_accept && (i_req.data.req_type == mms_pkg::REQ_READ);
        w_cmd.addr  = mms_pkg::AW'(mms_pkg::AW'(i_req.data.row)
                                   * mms_pkg::AW'(mms_pkg::DIM))
                    + mms_pkg::AW'(i_req.data.col);
        w_cmd.wdata = i_req.data.elem_value;
    end

    mms_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (w_cmd),
        .o_busy    (w_busy),
        .o_c_rdata (w_c_rdata),
        .o_min     (w_min)
    );

    // Product-valid flag: set by a compute, cleared by any load.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_product_ready <= 1'b0;
        end else if (w_accept) begin
            if (w_is_load) begin
                r_product_ready <= 1'b0;
            end else if (i_req.data.req_type == mms_pkg::REQ_COMPUTE) begin
                r_product_ready <= 1'b1;
            end
        end
    end

    // Pending read: the C word arrives in the cycle after acceptance.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_pend <= 1'b0;
        end else begin
            r_rd_pend <= w_cmd.rd_en;
        end
        if (w_cmd.rd_en) begin
            r_rd_in_range <= w_in_range;
            r_rd_ok       <= r_product_ready;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            if ((w_accept && !w_cmd.rd_en) || r_rd_pend) begin
                r_out_vld <= 1'b1;
            end else if (r_out_vld && o_rsp.ready) begin
                r_out_vld <= 1'b0;
            end
        end
        if (r_rd_pend) begin
            r_out.status        <= r_rd_ok ? mms_pkg::STATUS_OK
                                           : mms_pkg::STATUS_NO_PRODUCT;
            r_out.product_value <= (r_rd_ok && r_rd_in_range) ? w_c_rdata : '0;
            r_out.min_value     <= r_rd_ok ? w_min.value : '0;
            r_out.min_row       <= r_rd_ok ? w_min.row : '0;
            r_out.min_col       <= r_rd_ok ? w_min.col : '0;
        end else if (w_accept && !w_cmd.rd_en) begin
            r_out <= '0;
        end
    end

    assign o_rsp.valid = r_out_vld;
    assign o_rsp.data  = r_out;

endmodule
`default_nettype wire
